FILE: rtl/acp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// acp_pkg : shared types and constants for the autocorrelation periodicity block
// Frame size, word widths, payload structs, controller/datapath command and
// status structs.
// ---------------------------------------------------------------------------
package acp_pkg;

    localparam int FRAME_MAX   = 4096;
    localparam int ADDR_BITS   = $clog2(FRAME_MAX);
    localparam int CNT_BITS    = ADDR_BITS + 1;
    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 48;
    localparam int SUM_BITS    = 60;
    localparam int RATE_BITS   = 18;
    localparam int LAG_BITS    = 12;
    localparam logic [RATE_BITS-1:0] RATE_RESET = 18'd48000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0]        peak_ratio;
        logic [15:0]               periodicity;
        logic [LAG_BITS-1:0]       peak_lag;
        logic                      range_empty;
        logic                      frame_overflow;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic store_wr;      // write incoming sample
        logic lag_load;      // start lag sweep at lag zero
        logic lag_start;     // begin a new lag: clear accumulator, t=0
        logic mac_step;      // issue one product read
        logic lag_finish;    // fold accumulator into statistics
        logic lag_advance;   // step to next lag
        logic div_hr_start;  // start harmonic ratio division
        logic div_pe_start;  // start periodicity division
        logic mul_start;     // start n-products
        logic frame_clear;   // clear count and overflow flag
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic range_empty;
        logic mac_last;      // current read is the last product of this lag
        logic pipe_empty;    // no product still in flight
        logic lag_last;      // current lag is the maximum lag
        logic div_done;
        logic mul_done;
    } dp_stat_t;

endpackage : acp_pkg
`default_nettype wire

FILE: rtl/autocorrelation_periodicity.sv
`default_nettype none
// ---------------------------------------------------------------------------
// autocorrelation_periodicity : frame autocorrelation pitch periodicity
// Loads a frame, sweeps lag zero and the pitch lag range with one MAC,
// and reports harmonic ratio, periodicity and peak lag.
//
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------
//  input     | start / busy        | in_data (sample, last)
//  result    | valid (one cycle)   | result (ratio, periodicity, lag, flags)
//  config    | cfg_we              | cfg_data (sample rate in Hz)
//
// Samples are written into the store while idle; a sample with last ends
// the load. Lag zero and each searched lag are swept by the single
// multiply-accumulate unit with its two-read-port sample store, followed
// by the products, the two divisions and the result.
// Busy is high after the last sample until the result.
// Reset clears control state and sets the rate to 48000. The receiver
// cannot stall: valid lasts one cycle.
// ---------------------------------------------------------------------------
module autocorrelation_periodicity (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire acp_pkg::in_item_t             in_data,
    output logic                               valid,
    output acp_pkg::out_item_t                 result,
    input  wire logic                          cfg_we,
    input  wire logic [acp_pkg::RATE_BITS-1:0] cfg_data
);
    import acp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    acp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (in_data.last),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (valid)
    );

    acp_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_item  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .res      (result)
    );
endmodule : autocorrelation_periodicity
`default_nettype wire

FILE: rtl/acp_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// acp_ram : generic multi-port RAM
// One write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module acp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end
endmodule : acp_ram
`default_nettype wire

FILE: rtl/acp_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// acp_datapath : sample store, MAC unit, statistics and serial divider
// Lags are swept with one product per cycle through a two-read-port store;
// quotients come from a restoring divider one bit per cycle.
// ---------------------------------------------------------------------------
module acp_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [acp_pkg::RATE_BITS-1:0] cfg_data,
    input  wire acp_pkg::in_item_t             in_item,
    input  wire acp_pkg::dp_cmd_t              cmd,
    output acp_pkg::dp_stat_t                  stat,
    output acp_pkg::out_item_t                 res
);
    import acp_pkg::*;

    // configuration and lag range
    logic [RATE_BITS-1:0] rate_reg;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [RATE_BITS-1:0] min_lag_w, max_raw_w;
    logic [CNT_BITS-1:0]  max_lag_w;
    logic                 empty_w;

    // constant dividers: x/1000 and x/80 via reciprocal multiply
    always_comb
    begin
        min_lag_w = RATE_BITS'((48'(rate_reg) * 48'd268436) >> 28);
        max_raw_w = RATE_BITS'((48'(rate_reg) * 48'd3355444) >> 28);
        if ({1'b0, max_raw_w} >= (RATE_BITS + 1)'(count_reg))
        begin
            max_lag_w = count_reg - 1'b1;
        end
        else
        begin
            max_lag_w = CNT_BITS'(max_raw_w);
        end
        // count is at least one at the last sample; the clamp keeps it narrow
        empty_w = ({1'b0, min_lag_w} >= (RATE_BITS + 1)'(max_lag_w));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_RESET;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                rate_reg <= cfg_data;
            end
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // frame loading
    logic wr_ok;
    assign wr_ok = cmd.store_wr && (count_reg < CNT_BITS'(FRAME_MAX));
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.frame_clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.store_wr)
        begin
            if (wr_ok)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // lag sweep: lag 0 first, then minimum to maximum
    logic [CNT_BITS-1:0] lag_reg;
    logic [CNT_BITS-1:0] t_reg;
    logic                first_reg;   // sweeping lag zero
    logic                v1_reg, v2_reg;
    logic                mac_last_w;
    logic [ADDR_BITS-1:0] ra, rb;
    logic [SAMPLE_BITS-1:0] da, db;
    logic signed [2*SAMPLE_BITS-1:0] prod_reg;
    logic [ACC_BITS-1:0] acc_reg;

    assign mac_last_w = (t_reg + lag_reg + 1'b1) >= count_reg;
    assign ra = t_reg[ADDR_BITS-1:0];
    assign rb = ADDR_BITS'(t_reg + lag_reg);

    acp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(FRAME_MAX)) u_store (
        .clk       (clk),
        .wr_en     (wr_ok),
        .wr_addr   (count_reg[ADDR_BITS-1:0]),
        .wr_data   (in_item.sample),
        .rd_addr_a (ra),
        .rd_addr_b (rb),
        .rd_data_a (da),
        .rd_data_b (db)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_step;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lag_load)
        begin
            lag_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.lag_advance)
        begin
            first_reg <= 1'b0;
            lag_reg   <= first_reg ? CNT_BITS'(min_lag_w) : lag_reg + 1'b1;
        end
        if (cmd.lag_start)
        begin
            t_reg <= '0;
        end
        else if (cmd.mac_step)
        begin
            t_reg <= t_reg + 1'b1;
        end
        prod_reg <= $signed(da) * $signed(db);
        if (cmd.lag_start)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_BITS'(prod_reg);
        end
    end

    // statistics
    logic signed [ACC_BITS-1:0] r0_reg, max_reg, min_reg, accs;
    logic [SUM_BITS-1:0]        sum_reg;
    logic [LAG_BITS-1:0]        peak_reg;
    logic                       init_reg;
    assign accs = $signed(acc_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.lag_load)
        begin
            init_reg <= 1'b1;
            sum_reg  <= '0;
        end
        else if (cmd.lag_finish)
        begin
            if (first_reg)
            begin
                r0_reg <= accs;
            end
            else
            begin
                init_reg <= 1'b0;
                sum_reg  <= sum_reg + SUM_BITS'(accs);
                if (init_reg || accs > max_reg)
                begin
                    max_reg  <= accs;
                    peak_reg <= LAG_BITS'(lag_reg);
                end
                if (init_reg || accs < min_reg)
                begin
                    min_reg <= accs;
                end
            end
        end
    end

    // n-products, serial: max*n and (max-min)*n, shift-add over 13 bits
    logic [CNT_BITS-1:0] nbit_reg;
    logic [63:0]         mx_reg, dmx_reg, pn_reg, pd_reg;
    logic [3:0]          mcnt_reg;
    logic                mbusy_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
        end
        else if (cmd.mul_start)
        begin
            mbusy_reg <= 1'b1;
        end
        else if (mbusy_reg && mcnt_reg == 4'(CNT_BITS - 1))
        begin
            mbusy_reg <= 1'b0;
        end
    end
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            nbit_reg <= lag_reg - CNT_BITS'(min_lag_w) + 1'b1;
            mx_reg   <= 64'(max_reg);
            dmx_reg  <= 64'(max_reg) - 64'(min_reg);
            pn_reg   <= '0;
            pd_reg   <= '0;
            mcnt_reg <= '0;
        end
        else if (mbusy_reg)
        begin
            if (nbit_reg[0])
            begin
                pn_reg <= pn_reg + mx_reg;
                pd_reg <= pd_reg + dmx_reg;
            end
            mx_reg   <= mx_reg << 1;
            dmx_reg  <= dmx_reg << 1;
            nbit_reg <= nbit_reg >> 1;
            mcnt_reg <= mcnt_reg + 1'b1;
        end
    end

    // serial divider, 16 quotient bits, shared by both quotients
    logic [64:0] rem_reg;
    logic [63:0] den_reg;
    logic [15:0] q_reg;
    logic [4:0]  dcnt_reg;
    logic        dbusy_reg, sat_reg;
    logic [64:0] rem_sh;
    logic [63:0] num_w, den_w, pnum;
    logic [15:0] qround;
    logic        pe_ok;

    assign pnum  = pn_reg - 64'(sum_reg) - ((sum_reg[SUM_BITS-1]) ?
                   {{(64-SUM_BITS){1'b1}}, {SUM_BITS{1'b0}}} : 64'd0);
    assign pe_ok = !pnum[63] && (pnum != 0) && (pd_reg != 0);
    always_comb
    begin
        if (cmd.div_hr_start)
        begin
            num_w = max_reg[ACC_BITS-1] ? 64'(-max_reg) : 64'(max_reg);
            den_w = 64'(r0_reg);
        end
        else
        begin
            num_w = pnum;
            den_w = pd_reg;
        end
    end
    assign rem_sh = {rem_reg[63:0], 1'b0};
    assign qround = 16'((17'(q_reg) + 17'd1) >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
        end
        else if (cmd.div_hr_start || cmd.div_pe_start)
        begin
            dbusy_reg <= 1'b1;
        end
        else if (dbusy_reg && dcnt_reg == 5'd16)
        begin
            dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_hr_start || cmd.div_pe_start)
        begin
            rem_reg  <= {1'b0, num_w};
            den_reg  <= den_w;
            sat_reg  <= num_w >= den_w;
            q_reg    <= '0;
            dcnt_reg <= '0;
        end
        else if (dbusy_reg && dcnt_reg != 5'd16)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                q_reg   <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[14:0], 1'b0};
            end
        end
    end

    // result assembly
    logic [16:0] qmag;
    logic [15:0] hr_reg, pe_reg;
    logic        hr_sel_reg;
    assign qmag = sat_reg ? 17'd32768 : {1'b0, qround};
    always_ff @(posedge clk)
    begin
        if (cmd.div_hr_start)
        begin
            hr_sel_reg <= 1'b1;
            hr_reg     <= '0;
            pe_reg     <= '0;
        end
        else if (cmd.div_pe_start)
        begin
            hr_sel_reg <= 1'b0;
        end
        else if (dbusy_reg && dcnt_reg == 5'd16)
        begin
            if (hr_sel_reg)
            begin
                if (max_reg[ACC_BITS-1])
                begin
                    hr_reg <= 16'(-qmag);
                end
                else
                begin
                    hr_reg <= qmag[15] ? 16'd32767 : qmag[15:0];
                end
            end
            else
            begin
                pe_reg <= pe_ok ? 16'(qmag) : 16'd0;
            end
        end
    end

    logic r0_pos;
    assign r0_pos = !r0_reg[ACC_BITS-1] && (r0_reg != 0);

    always_comb
    begin
        stat.range_empty = empty_w;
        stat.mac_last    = mac_last_w;
        stat.pipe_empty  = !v1_reg && !v2_reg;
        stat.lag_last    = !first_reg && (lag_reg == max_lag_w);
        stat.div_done    = dbusy_reg && dcnt_reg == 5'd16;
        stat.mul_done    = !mbusy_reg;
        res.range_empty    = empty_w;
        res.frame_overflow = ovf_reg;
        if (empty_w)
        begin
            res.peak_ratio  = '0;
            res.periodicity = '0;
            res.peak_lag    = '0;
        end
        else
        begin
            res.peak_ratio  = r0_pos ? $signed(hr_reg) : '0;
            res.periodicity = r0_pos ? pe_reg : '0;
            res.peak_lag    = peak_reg;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(FRAME_MAX))
        else $error("sample count beyond frame size");
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_BITS'(FRAME_MAX)) |-> !wr_ok)
        else $error("write into full store");
    a_div_one_user: assert property (@(posedge clk) disable iff (!rst_n)
        dbusy_reg && dcnt_reg != 5'd16 |-> !cmd.div_hr_start && !cmd.div_pe_start)
        else $error("divider restarted while busy");
`endif
endmodule : acp_datapath
`default_nettype wire

FILE: rtl/acp_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// acp_ctrl : sequencer for load, lag sweep, products, division and result
// ---------------------------------------------------------------------------
module acp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              last,
    input  wire acp_pkg::dp_stat_t stat,
    output acp_pkg::dp_cmd_t       cmd,
    output logic                   busy,
    output logic                   done
);
    import acp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LAGST = 4'd1;
    localparam logic [3:0] S_MAC   = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_FOLD  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DHR   = 4'd6;
    localparam logic [3:0] S_DPE   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_PREP  = 4'd9;
    localparam logic [3:0] S_WAIT  = 4'd10;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done       = 1'b0;
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.store_wr = 1'b1;
                    if (last)
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                // count now final; range known
                if (stat.range_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.lag_load = 1'b1;
                    state_next   = S_LAGST;
                end
            end
            S_LAGST:
            begin
                cmd.lag_start = 1'b1;
                state_next    = S_MAC;
            end
            S_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (stat.mac_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    cmd.lag_finish = 1'b1;
                    state_next     = S_FOLD;
                end
            end
            S_FOLD:
            begin
                if (stat.lag_last)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
                else
                begin
                    cmd.lag_advance = 1'b1;
                    state_next      = S_LAGST;
                end
            end
            S_MUL:
            begin
                if (stat.mul_done)
                begin
                    cmd.div_hr_start = 1'b1;
                    state_next       = S_DHR;
                end
            end
            S_DHR:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DPE;
                end
            end
            S_DPE:
            begin
                cmd.div_pe_start = 1'b1;
                state_next       = S_WAIT;
            end
            S_WAIT:
            begin
                // second quotient lands in its register as this state ends on div_done
                if (stat.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done            = 1'b1;
                cmd.frame_clear = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cmd.frame_clear)
        else $error("result without frame clear");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == S_IDLE)
        else $error("not idle after result");
    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_wr |-> state_reg == S_IDLE)
        else $error("store write outside load");
`endif
endmodule : acp_ctrl
`default_nettype wire
